// File: sv/lfcdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfcdc_pkg: shared types and constants of the line-follow drive controller
// Holds the fixed field widths, fixed-point limits, register indexes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package lfcdc_pkg;

   // Fixed field widths.
   localparam int GAIN_W    = 24;
   localparam int TGT_W     = 16;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 3;
   localparam int WHEEL_W   = 16;
   localparam int YAW_W     = 16;
   localparam int MOT_W     = 16;

   // Internal fixed-point widths.
   localparam int Q_W      = 14;  // quotient bits, the bias magnitude stays below 2^14
   localparam int BIAS_W   = 16;  // Q7.8 steering bias
   localparam int ERR_W    = 18;  // speed error, integer count
   localparam int ACC_W    = 17;  // speed accumulator, clamped to +-40960
   localparam int RERR_W   = 29;  // yaw-rate error, Q.8
   localparam int X_W      = 30;  // operand of the shared multiplier
   localparam int PROD_W   = GAIN_W + X_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int TURN_W   = SUM_W - 8;
   localparam int MSUM_W   = TURN_W + 1;

   // Scaling and limits.
   localparam int BIAS_SCALE   = 12800;
   localparam int PRESENCE_MIN = 25;
   localparam int DEADBAND     = 128;
   localparam int SPEED_LIMIT  = 40960;
   localparam int MOTOR_MAX    = 32767;
   localparam int MOTOR_MIN    = -32768;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SPEED_TARGET = 3'd0,
      REG_SPEED_KP     = 3'd1,
      REG_SPEED_KI     = 3'd2,
      REG_SPEED_KD     = 3'd3,
      REG_RATE_KP      = 3'd4,
      REG_RATE_KD      = 3'd5,
      REG_STEER_KP     = 3'd6,
      REG_STEER_KD     = 3'd7
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_MAC  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

endpackage

// File: sv/lfcdc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfcdc_req_if: input channel of the line-follow drive controller
// Carries one control tick: three line samples, two wheel counts, yaw rate.
// ----------------------------------------------------------------------------
interface lfcdc_req_if #(
   parameter int ADC_BITS = 12
);
   logic                                   valid;
   logic                                   ready;
   logic [ADC_BITS-1:0]                    line_left;
   logic [ADC_BITS-1:0]                    line_mid;
   logic [ADC_BITS-1:0]                    line_right;
   logic signed [lfcdc_pkg::WHEEL_W-1:0]   wheel_count_left;
   logic signed [lfcdc_pkg::WHEEL_W-1:0]   wheel_count_right;
   logic signed [lfcdc_pkg::YAW_W-1:0]     yaw_rate;

   modport source (
      output valid, line_left, line_mid, line_right,
             wheel_count_left, wheel_count_right, yaw_rate,
      input  ready
   );
   modport sink (
      input  valid, line_left, line_mid, line_right,
             wheel_count_left, wheel_count_right, yaw_rate,
      output ready
   );
endinterface

// File: sv/lfcdc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfcdc_rsp_if: result channel of the line-follow drive controller
// Carries the left and right motor commands of one control tick.
// ----------------------------------------------------------------------------
interface lfcdc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lfcdc_pkg::MOT_W-1:0]   motor_left;
   logic signed [lfcdc_pkg::MOT_W-1:0]   motor_right;

   modport source (output valid, motor_left, motor_right, input ready);
   modport sink (input valid, motor_left, motor_right, output ready);
endinterface

// File: sv/lfcdc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfcdc_div: serial restoring divider for the steering bias
// Produces one quotient bit a cycle; the quotient is known to fit Q_W bits.
// ----------------------------------------------------------------------------
module lfcdc_div #(
   parameter int ADC_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ADC_BITS+13:0]           dividend,
   input  logic [ADC_BITS:0]              divisor,
   output logic                           done,
   output logic [lfcdc_pkg::Q_W-1:0]      quotient
);
   localparam int REM_W = ADC_BITS + 14;
   localparam int CNT_W = $clog2(lfcdc_pkg::Q_W);

   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [REM_W-1:0]            dsh_ff, dsh_in;
   logic [lfcdc_pkg::Q_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   // One compare and subtract step per cycle.
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = {divisor, 13'b0};
         q_in    = '0;
         cnt_in  = CNT_W'(lfcdc_pkg::Q_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[lfcdc_pkg::Q_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[lfcdc_pkg::Q_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   // The bias magnitude never exceeds the full-scale value.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (q_ff <= lfcdc_pkg::Q_W'(lfcdc_pkg::BIAS_SCALE)))
      else $error("divider quotient above full scale");

   // The completion pulse comes once the divider has gone idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

   // A new division only starts while the divider is idle.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
endmodule

// File: sv/line_follow_cascaded_drive_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_cascaded_drive_controller: steering and speed loops of a
// line-following car
// Turns line samples, wheel counts and yaw rate into two motor commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one control tick per transfer; rsp_chan returns one pair
//   of motor commands per tick. csr_* writes a gain or the speed target and
//   must only be used while no tick is in flight.
//   With the line present a tick passes from its transfer to a valid result
//   through the serial bias divider (load, 14 quotient bits, then taking the
//   quotient), then through the multiply phases, in which one shared
//   24 x 30 bit multiplier and its accumulator work through the seven loop
//   products, each multiplied and then accumulated, and then the outputs are
//   formed. Without the line the divider is skipped. req_ready returns high
//   the cycle after the result is loaded, so a new tick is accepted only
//   once the previous tick has been computed and its result loaded; the
//   divider and the shared multiplier set how long that takes.
//   The result sits in an output register. If the receiver stalls, the next
//   tick is still accepted and computed, and it waits in the final state until
//   the previous result has been transferred.
//   Reset (synchronous) restores the default gains and target and clears the
//   loop history and the speed accumulator.
// ----------------------------------------------------------------------------
module line_follow_cascaded_drive_controller #(
   parameter int ADC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   lfcdc_req_if.sink                           req_chan,
   lfcdc_rsp_if.source                         rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [lfcdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lfcdc_pkg::CSR_W-1:0]         csr_wdata
);
   localparam int G = lfcdc_pkg::GAIN_W;
   localparam int X = lfcdc_pkg::X_W;
   localparam int S = lfcdc_pkg::SUM_W;

   // Configuration registers.
   logic signed [lfcdc_pkg::TGT_W-1:0] speed_target_ff;
   logic signed [G-1:0] speed_kp_ff, speed_ki_ff, speed_kd_ff;
   logic signed [G-1:0] rate_kp_ff, rate_kd_ff, steer_kp_ff, steer_kd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_target_ff <= 16'sd20;
         speed_kp_ff     <= 24'sd40960;
         speed_ki_ff     <= 24'sd12288;
         speed_kd_ff     <= 24'sd40960;
         rate_kp_ff      <= 24'sd205;
         rate_kd_ff      <= 24'sd41;
         steer_kp_ff     <= 24'sd1146880;
         steer_kd_ff     <= -24'sd409600;
      end else if (csr_wr_en) begin
         case (lfcdc_pkg::csr_index_type'(csr_index))
            lfcdc_pkg::REG_SPEED_TARGET: speed_target_ff <= csr_wdata[15:0];
            lfcdc_pkg::REG_SPEED_KP:     speed_kp_ff     <= csr_wdata;
            lfcdc_pkg::REG_SPEED_KI:     speed_ki_ff     <= csr_wdata;
            lfcdc_pkg::REG_SPEED_KD:     speed_kd_ff     <= csr_wdata;
            lfcdc_pkg::REG_RATE_KP:      rate_kp_ff      <= csr_wdata;
            lfcdc_pkg::REG_RATE_KD:      rate_kd_ff      <= csr_wdata;
            lfcdc_pkg::REG_STEER_KP:     steer_kp_ff     <= csr_wdata;
            lfcdc_pkg::REG_STEER_KD:     steer_kd_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input transfer and the bias set-up.
   lfcdc_pkg::state_type state_ff, state_in;
   logic accept;
   logic [ADC_BITS+1:0] line_sum;
   logic [ADC_BITS:0]   side_sum;
   logic                line_present, side_neg;
   logic [ADC_BITS-1:0] side_diff;
   logic [ADC_BITS+13:0] div_num;
   logic                div_done;
   logic [lfcdc_pkg::Q_W-1:0] div_q;
   logic signed [lfcdc_pkg::WHEEL_W+2:0] speed_diff;
   logic signed [lfcdc_pkg::ERR_W-1:0]   e0_calc;

   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == lfcdc_pkg::ST_IDLE);
   assign line_sum = (ADC_BITS+2)'(req_chan.line_left) +
                     (ADC_BITS+2)'(req_chan.line_mid) +
                     (ADC_BITS+2)'(req_chan.line_right);
   assign side_sum = (ADC_BITS+1)'(req_chan.line_left) +
                     (ADC_BITS+1)'(req_chan.line_right);
   assign line_present = (line_sum > (ADC_BITS+2)'(lfcdc_pkg::PRESENCE_MIN)) &&
                         (side_sum != '0);
   assign side_neg  = req_chan.line_left < req_chan.line_right;
   assign side_diff = side_neg ? (req_chan.line_right - req_chan.line_left)
                               : (req_chan.line_left - req_chan.line_right);
   assign div_num   = (ADC_BITS+14)'(side_diff) * 14'(lfcdc_pkg::BIAS_SCALE);

   // Speed error, halved with truncation toward zero.
   always_comb begin
      speed_diff = (lfcdc_pkg::WHEEL_W+3)'(speed_target_ff) *
                   (lfcdc_pkg::WHEEL_W+3)'(2)
                 - (lfcdc_pkg::WHEEL_W+3)'(req_chan.wheel_count_left)
                 - (lfcdc_pkg::WHEEL_W+3)'(req_chan.wheel_count_right);
      if (speed_diff < 0) begin
         e0_calc = lfcdc_pkg::ERR_W'((speed_diff + 1) >>> 1);
      end else begin
         e0_calc = lfcdc_pkg::ERR_W'(speed_diff >>> 1);
      end
   end

   lfcdc_div #(.ADC_BITS(ADC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && line_present),
      .dividend (div_num),
      .divisor  (side_sum),
      .done     (div_done),
      .quotient (div_q)
   );

   // Per-tick working registers and loop history.
   logic                                 neg_ff;
   logic signed [lfcdc_pkg::YAW_W-1:0]   yaw_ff;
   logic signed [lfcdc_pkg::BIAS_W-1:0]  bias_ff, prev_bias_ff;
   logic signed [lfcdc_pkg::ERR_W-1:0]   e0_ff, e1_ff, e2_ff;
   logic signed [lfcdc_pkg::ACC_W-1:0]   acc_ff;
   logic signed [lfcdc_pkg::RERR_W-1:0]  rerr_ff, prev_rerr_ff;
   logic signed [lfcdc_pkg::TURN_W-1:0]  turn_ff;
   logic signed [lfcdc_pkg::PROD_W-1:0]  prod_ff;
   logic signed [S-1:0]                  sum_ff;
   logic [3:0]                           phase_ff;
   logic                                 rsp_valid_ff;
   logic signed [lfcdc_pkg::MOT_W-1:0]   mot_l_ff, mot_r_ff;

   // Operand selection for the shared multiplier.
   logic signed [G-1:0] mac_gain;
   logic signed [X-1:0] mac_x;
   always_comb begin
      case (phase_ff[3:1])
         3'd0: begin
            mac_gain = steer_kp_ff;
            mac_x    = X'(bias_ff);
         end
         3'd1: begin
            mac_gain = steer_kd_ff;
            mac_x    = X'(bias_ff) - X'(prev_bias_ff);
         end
         3'd2: begin
            mac_gain = rate_kp_ff;
            mac_x    = X'(rerr_ff);
         end
         3'd3: begin
            mac_gain = rate_kd_ff;
            mac_x    = X'(rerr_ff) - X'(prev_rerr_ff);
         end
         3'd4: begin
            mac_gain = speed_kp_ff;
            mac_x    = X'(e0_ff) - X'(e1_ff);
         end
         3'd5: begin
            mac_gain = speed_ki_ff;
            mac_x    = X'(e0_ff);
         end
         3'd6: begin
            mac_gain = speed_kd_ff;
            mac_x    = X'(e0_ff) - (X'(e1_ff) <<< 1) + X'(e2_ff);
         end
         default: begin
            mac_gain = '0;
            mac_x    = '0;
         end
      endcase
   end

   // Accumulation results taken at the end of each loop.
   logic signed [S-1:0]   new_sum, rerr_full;
   logic signed [S:0]     acc_full;
   logic signed [lfcdc_pkg::ACC_W-1:0] acc_clamped;
   assign new_sum   = sum_ff + S'(prod_ff);
   assign rerr_full = (new_sum >>> 12) - (S'(yaw_ff) <<< 8);
   assign acc_full  = (S+1)'(acc_ff) + (S+1)'(new_sum);
   always_comb begin
      if (acc_full > (S+1)'(lfcdc_pkg::SPEED_LIMIT)) begin
         acc_clamped = lfcdc_pkg::ACC_W'(lfcdc_pkg::SPEED_LIMIT);
      end else if (acc_full < -(S+1)'(lfcdc_pkg::SPEED_LIMIT)) begin
         acc_clamped = -lfcdc_pkg::ACC_W'(lfcdc_pkg::SPEED_LIMIT);
      end else begin
         acc_clamped = lfcdc_pkg::ACC_W'(acc_full);
      end
   end

   // Motor commands: truncate toward zero, then saturate.
   localparam int M = lfcdc_pkg::MSUM_W;
   logic signed [M-1:0] msum_l, msum_r, mq_l, mq_r;
   logic signed [lfcdc_pkg::MOT_W-1:0] mot_l, mot_r;
   always_comb begin
      msum_l = M'(acc_ff) + M'(turn_ff);
      msum_r = M'(acc_ff) - M'(turn_ff);
      mq_l = (msum_l < 0) ? ((msum_l + M'(4095)) >>> 12) : (msum_l >>> 12);
      mq_r = (msum_r < 0) ? ((msum_r + M'(4095)) >>> 12) : (msum_r >>> 12);
      if (mq_l > M'(lfcdc_pkg::MOTOR_MAX)) mot_l = 16'sh7fff;
      else if (mq_l < M'(lfcdc_pkg::MOTOR_MIN)) mot_l = -16'sh8000;
      else mot_l = lfcdc_pkg::MOT_W'(mq_l);
      if (mq_r > M'(lfcdc_pkg::MOTOR_MAX)) mot_r = 16'sh7fff;
      else if (mq_r < M'(lfcdc_pkg::MOTOR_MIN)) mot_r = -16'sh8000;
      else mot_r = lfcdc_pkg::MOT_W'(mq_r);
   end

   logic out_load;
   assign out_load = (state_ff == lfcdc_pkg::ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfcdc_pkg::ST_IDLE: begin
            if (accept) state_in = line_present ? lfcdc_pkg::ST_DIV : lfcdc_pkg::ST_MAC;
         end
         lfcdc_pkg::ST_DIV: begin
            if (div_done) state_in = lfcdc_pkg::ST_MAC;
         end
         lfcdc_pkg::ST_MAC: begin
            if (phase_ff == 4'd13) state_in = lfcdc_pkg::ST_OUT;
         end
         lfcdc_pkg::ST_OUT: begin
            if (out_load) state_in = lfcdc_pkg::ST_IDLE;
         end
         default: state_in = lfcdc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfcdc_pkg::ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         prev_bias_ff <= '0;
         e1_ff        <= '0;
         e2_ff        <= '0;
         acc_ff       <= '0;
         prev_rerr_ff <= '0;
      end else begin
         state_ff <= state_in;
         // Tick capture.
         if (accept) begin
            phase_ff <= '0;
            neg_ff   <= side_neg;
            yaw_ff   <= req_chan.yaw_rate;
            e0_ff    <= e0_calc;
            if (!line_present) bias_ff <= '0;
         end
         // Bias with deadband once the divider finishes.
         if (state_ff == lfcdc_pkg::ST_DIV && div_done) begin
            if (div_q < lfcdc_pkg::Q_W'(lfcdc_pkg::DEADBAND)) bias_ff <= '0;
            else if (neg_ff) bias_ff <= -lfcdc_pkg::BIAS_W'(div_q);
            else bias_ff <= lfcdc_pkg::BIAS_W'(div_q);
         end
         // Multiply on even phases, accumulate on odd phases.
         if (state_ff == lfcdc_pkg::ST_MAC) begin
            phase_ff <= phase_ff + 1'b1;
            if (!phase_ff[0]) begin
               prod_ff <= mac_gain * mac_x;
               if (phase_ff == 4'd0) sum_ff <= '0;
            end else if (phase_ff == 4'd3) begin
               rerr_ff <= lfcdc_pkg::RERR_W'(rerr_full);
               sum_ff  <= '0;
            end else if (phase_ff == 4'd7) begin
               turn_ff <= lfcdc_pkg::TURN_W'(new_sum >>> 8);
               sum_ff  <= '0;
            end else if (phase_ff == 4'd13) begin
               acc_ff  <= acc_clamped;
            end else begin
               sum_ff  <= new_sum;
            end
         end
         // Result register and history update.
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            mot_l_ff     <= mot_l;
            mot_r_ff     <= mot_r;
            prev_bias_ff <= bias_ff;
            prev_rerr_ff <= rerr_ff;
            e2_ff        <= e1_ff;
            e1_ff        <= e0_ff;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.motor_left  = mot_l_ff;
   assign rsp_chan.motor_right = mot_r_ff;

   // The speed accumulator stays inside its clamp.
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      (acc_ff <= 17'sd40960) && (acc_ff >= -17'sd40960))
      else $error("speed accumulator out of range");

   // A transfer on the input closes the input until the tick is done.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("input accepted twice in a row");

   // The applied bias is zero or outside the deadband.
   a_bias_deadband: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lfcdc_pkg::ST_MAC) |->
         (bias_ff == 0 || bias_ff >= 16'sd128 || bias_ff <= -16'sd128))
      else $error("bias inside deadband");
endmodule
